// ===== rtl/core/v3n_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants of the vector normalize unit
// Widths of the component, square, quotient and root paths, and the words.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRACTION_BITS  = 14;

    // sum of three squares fits in twice the component width
    localparam int SUM_W      = 2 * COMPONENT_BITS;
    // quotient sq * 2^(2F) / sum is at most 2^(2F)
    localparam int QUO_W      = 2 * FRACTION_BITS + 1;
    localparam int ROOT_W     = FRACTION_BITS + 1;
    localparam int OUT_W      = FRACTION_BITS + 2;
    localparam int DIV_STEPS  = 2 * FRACTION_BITS + 1;
    localparam int SQRT_STEPS = FRACTION_BITS + 1;
    localparam int FRONT_STAGES = 3;
    localparam int LATENCY    = FRONT_STAGES + DIV_STEPS + SQRT_STEPS + 1;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] x_in;
        logic signed [COMPONENT_BITS-1:0] y_in;
        logic signed [COMPONENT_BITS-1:0] z_in;
    } t_vec_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] x_unit;
        logic signed [OUT_W-1:0] y_unit;
        logic signed [OUT_W-1:0] z_unit;
        logic                    zero_length;
    } t_vec_out;

    // side-band that travels alongside the arithmetic
    typedef struct packed {
        logic       valid;
        logic [2:0] neg;
        logic       zero;
    } t_ctl;

endpackage
`default_nettype wire

// ===== rtl/core/v3n_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_front: magnitude, square and sum stages
// Three register stages: absolute value, squares, sum of squares.
// ----------------------------------------------------------------------------
module v3n_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire v3n_pkg::t_vec_in            i_vec,
    output logic [v3n_pkg::SUM_W-1:0]        o_sq [3],
    output logic [v3n_pkg::SUM_W-1:0]        o_sum,
    output v3n_pkg::t_ctl                    o_ctl
);
    import v3n_pkg::*;

    logic [COMPONENT_BITS-1:0] r_mag [3];
    logic [SUM_W-1:0]          r_sq2 [3];
    logic [SUM_W-1:0]          r_sq3 [3];
    logic [SUM_W-1:0]          r_sum;
    t_ctl                      r_ctl1, r_ctl2, r_ctl3;
    logic signed [COMPONENT_BITS-1:0] w_c [3];
    logic [SUM_W-1:0]          n_sum;

    assign w_c[0] = i_vec.x_in;
    assign w_c[1] = i_vec.y_in;
    assign w_c[2] = i_vec.z_in;
    assign n_sum  = r_sq2[0] + r_sq2[1] + r_sq2[2];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 3; l++) begin
            r_mag[l] <= w_c[l][COMPONENT_BITS-1] ? COMPONENT_BITS'(-w_c[l])
                                                  : COMPONENT_BITS'(w_c[l]);
            r_sq2[l] <= SUM_W'(r_mag[l]) * SUM_W'(r_mag[l]);
            r_sq3[l] <= r_sq2[l];
        end
        r_sum <= n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_ctl3 <= '0;
        end else begin
            r_ctl1 <= '{valid: i_valid,
                        neg:   {w_c[2][COMPONENT_BITS-1], w_c[1][COMPONENT_BITS-1],
                                w_c[0][COMPONENT_BITS-1]},
                        zero:  1'b0};
            r_ctl2 <= r_ctl1;
            // zero flag lines up with the sum that leaves this stage
            r_ctl3 <= '{valid: r_ctl2.valid, neg: r_ctl2.neg, zero: (n_sum == '0)};
        end
    end

    assign o_sq  = r_sq3;
    assign o_sum = r_sum;
    assign o_ctl = r_ctl3;

endmodule
`default_nettype wire

// ===== rtl/core/v3n_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_div_cell: one restoring division step
// Produces one quotient bit and hands remainder, quotient, divisor on.
// ----------------------------------------------------------------------------
module v3n_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  wire logic                        i_clk,
    input  wire logic [v3n_pkg::SUM_W-1:0]   i_rem,
    input  wire logic [v3n_pkg::QUO_W-1:0]   i_quo,
    input  wire logic [v3n_pkg::SUM_W-1:0]   i_den,
    output logic [v3n_pkg::SUM_W-1:0]        o_rem,
    output logic [v3n_pkg::QUO_W-1:0]        o_quo,
    output logic [v3n_pkg::SUM_W-1:0]        o_den
);
    import v3n_pkg::*;

    logic [SUM_W:0]   w_shift;
    logic             w_ge;
    logic [SUM_W-1:0] n_rem;
    logic [SUM_W-1:0] r_rem, r_den;
    logic [QUO_W-1:0] r_quo;

    // first step compares the numerator itself, later steps shift first
    assign w_shift = FIRST ? {1'b0, i_rem} : {i_rem, 1'b0};
    assign w_ge    = w_shift >= {1'b0, i_den};
    assign n_rem   = w_ge ? SUM_W'(w_shift - {1'b0, i_den}) : SUM_W'(w_shift);

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= {i_quo[QUO_W-2:0], w_ge};
        r_den <= i_den;
    end

    assign o_rem = r_rem;
    assign o_quo = r_quo;
    assign o_den = r_den;

endmodule
`default_nettype wire

// ===== rtl/core/v3n_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_sqrt_cell: one digit of the integer square root
// Trial subtract against root + 4^STEP, one result bit per cell.
// ----------------------------------------------------------------------------
module v3n_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire logic                        i_clk,
    input  wire logic [v3n_pkg::QUO_W-1:0]   i_rad,
    input  wire logic [v3n_pkg::QUO_W-1:0]   i_root,
    output logic [v3n_pkg::QUO_W-1:0]        o_rad,
    output logic [v3n_pkg::QUO_W-1:0]        o_root
);
    import v3n_pkg::*;

    localparam logic [QUO_W:0] BIT = (QUO_W+1)'(1) << (2 * STEP);

    logic [QUO_W:0]   w_trial;
    logic             w_ge;
    logic [QUO_W-1:0] r_rad, r_root;

    assign w_trial = {1'b0, i_root} + BIT;
    assign w_ge    = {1'b0, i_rad} >= w_trial;

    always_ff @(posedge i_clk) begin
        r_rad  <= w_ge ? QUO_W'({1'b0, i_rad} - w_trial) : i_rad;
        r_root <= w_ge ? QUO_W'({2'b0, i_root[QUO_W-1:1]} + BIT)
                       : {1'b0, i_root[QUO_W-1:1]};
    end

    assign o_rad  = r_rad;
    assign o_root = r_root;

endmodule
`default_nettype wire

// ===== rtl/core/vector3_normalize_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// vector3_normalize_unit: scales a 3D vector to unit length in signed Q1.14
// Pipeline of magnitude/square/sum stages, division cells and root cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input word (x_in, y_in, z_in) on i_vec is taken at a clock edge where
//   i_start is high and o_busy is low. o_busy is low at all times after
//   reset, so a new word can be taken every cycle.
//   The result word appears on o_result for exactly one cycle with o_strobe
//   high, once the accepted word has passed 3 front stages, 29 division
//   cells (one quotient bit each), 15 root cells (one root bit each) and one
//   output register. Throughput is one word per clock.
//   Each component is isqrt(c*c*2^28 / S), S the sum of squares, clamped to
//   16384 and given the sign of c. An all-zero vector sets zero_length and
//   returns zero components.
//   The receiver cannot hold off results; none is needed since no stage
//   ever stalls.
//   Reset (synchronous, active low) clears all valid bits; o_busy is set
//   during reset and cleared by a clock edge at which i_rst_n is high.
// ----------------------------------------------------------------------------
module vector3_normalize_unit (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire v3n_pkg::t_vec_in  i_vec,
    output logic                   o_strobe,
    output v3n_pkg::t_vec_out      o_result
);
    import v3n_pkg::*;

    localparam int TAPS = DIV_STEPS + SQRT_STEPS;
    localparam logic [ROOT_W-1:0] UNIT_ONE = ROOT_W'(1) << FRACTION_BITS;

    logic r_busy;
    logic w_accept;

    logic [SUM_W-1:0] w_sq [3];
    logic [SUM_W-1:0] w_sum;
    t_ctl             w_ctl0;

    // division and root chains, one row per lane
    logic [SUM_W-1:0] w_rem  [3][DIV_STEPS+1];
    logic [QUO_W-1:0] w_quo  [3][DIV_STEPS+1];
    logic [SUM_W-1:0] w_den  [3][DIV_STEPS+1];
    logic [QUO_W-1:0] w_rad  [3][SQRT_STEPS+1];
    logic [QUO_W-1:0] w_root [3][SQRT_STEPS+1];

    // side-band shift line that follows the cells
    t_ctl r_ctl [TAPS];

    logic [ROOT_W-1:0]       w_mag  [3];
    logic signed [OUT_W-1:0] w_unit [3];
    t_vec_out                r_result;
    logic                    r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign o_busy   = r_busy;
    assign w_accept = i_start && !r_busy;

    v3n_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_vec   (i_vec),
        .o_sq    (w_sq),
        .o_sum   (w_sum),
        .o_ctl   (w_ctl0)
    );

    for (genvar l = 0; l < 3; l++) begin : g_lane
        assign w_rem[l][0] = w_sq[l];
        assign w_quo[l][0] = '0;
        assign w_den[l][0] = w_sum;

        for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
            v3n_div_cell #(.FIRST(k == 0)) u_div (
                .i_clk (i_clk),
                .i_rem (w_rem[l][k]),
                .i_quo (w_quo[l][k]),
                .i_den (w_den[l][k]),
                .o_rem (w_rem[l][k+1]),
                .o_quo (w_quo[l][k+1]),
                .o_den (w_den[l][k+1])
            );
        end

        assign w_rad[l][0]  = w_quo[l][DIV_STEPS];
        assign w_root[l][0] = '0;

        // root digits run from the top bit down
        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
            v3n_sqrt_cell #(.STEP(SQRT_STEPS - 1 - k)) u_sqrt (
                .i_clk  (i_clk),
                .i_rad  (w_rad[l][k]),
                .i_root (w_root[l][k]),
                .o_rad  (w_rad[l][k+1]),
                .o_root (w_root[l][k+1])
            );
        end

        // clamp to one, then apply sign
        assign w_mag[l]  = (w_root[l][SQRT_STEPS][ROOT_W-1:0] > UNIT_ONE)
                           ? UNIT_ONE : w_root[l][SQRT_STEPS][ROOT_W-1:0];
        assign w_unit[l] = r_ctl[TAPS-1].neg[l] ? -OUT_W'(w_mag[l]) : OUT_W'(w_mag[l]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TAPS; t++) begin
                r_ctl[t] <= '0;
            end
            r_strobe <= 1'b0;
        end else begin
            r_ctl[0] <= w_ctl0;
            for (int t = 1; t < TAPS; t++) begin
                r_ctl[t] <= r_ctl[t-1];
            end
            r_strobe <= r_ctl[TAPS-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl[TAPS-1].zero) begin
            r_result <= '{x_unit: '0, y_unit: '0, z_unit: '0, zero_length: 1'b1};
        end else begin
            r_result <= '{x_unit: w_unit[0], y_unit: w_unit[1], z_unit: w_unit[2],
                          zero_length: 1'b0};
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== rtl/core/v3n_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// v3n_checker: port-level checks of the vector normalize unit
// Latency, zero-vector output, output range and o_busy after reset.
// ----------------------------------------------------------------------------
module v3n_checker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              o_busy,
    input  wire logic              o_strobe,
    input  wire v3n_pkg::t_vec_out o_result
);
    import v3n_pkg::*;

    localparam logic signed [OUT_W-1:0] POS_ONE = OUT_W'(1) << FRACTION_BITS;
    localparam logic signed [OUT_W-1:0] NEG_ONE = -POS_ONE;

    logic w_acc;
    assign w_acc = i_start && !o_busy;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe == $past(w_acc, LATENCY))
        else $error("result word not LATENCY cycles after accepted word");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.zero_length) |->
        (o_result.x_unit == '0 && o_result.y_unit == '0 && o_result.z_unit == '0))
        else $error("zero vector gave nonzero components");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.x_unit <= POS_ONE && o_result.x_unit >= NEG_ONE &&
                      o_result.y_unit <= POS_ONE && o_result.y_unit >= NEG_ONE &&
                      o_result.z_unit <= POS_ONE && o_result.z_unit >= NEG_ONE))
        else $error("unit component out of range");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !o_busy)
        else $error("busy after reset release");

endmodule

bind vector3_normalize_unit v3n_checker u_v3n_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
`default_nettype wire
